[sv/ascon_pkg.sv]
package ascon_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WORDS    = 5;
    localparam int unsigned RND_W    = 4;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [RND_W-1:0] INIT_START  = 4'd0;
    localparam logic [RND_W-1:0] BLOCK_START = 4'd6;
    localparam logic [RND_W-1:0] ROUND_LAST  = 4'd11;

    localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;

    localparam logic [WORD_W-1:0] ASCON128_IV = 64'h80400c0600000000;
    localparam logic [WORD_W-1:0] DOMAIN_SEP  = 64'h0000000000000001;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 2'd3;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_sponge;

    typedef struct packed {
        logic              kind;
        logic [63:0]       block_data;
        logic [CNT_W-1:0]  byte_count;
        logic              first_block;
        logic              last_block;
        logic [63:0]       expected_tag_high;
        logic [63:0]       expected_tag_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0]       out_data;
        logic [CNT_W-1:0]  out_byte_count;
        logic [63:0]       tag_high;
        logic [63:0]       tag_low;
        logic              tag_valid;
        logic              auth_ok;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ABSORB,
        ST_BLOCK,
        ST_FINAL,
        ST_DONE
    } t_state;

    function automatic logic [WORD_W-1:0] rotr64(logic [WORD_W-1:0] v, int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // One round of the permutation with round index r.
    function automatic t_sponge ascon_round(t_sponge s, logic [RND_W-1:0] r);
        logic [WORD_W-1:0] x0, x1, x2, x3, x4;
        logic [WORD_W-1:0] t0, t1, t2, t3, t4;
        t_sponge           o;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, ~r, r};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        o[0] = x0 ^ rotr64(x0, 19) ^ rotr64(x0, 28);
        o[1] = x1 ^ rotr64(x1, 61) ^ rotr64(x1, 39);
        o[2] = x2 ^ rotr64(x2, 1) ^ rotr64(x2, 6);
        o[3] = x3 ^ rotr64(x3, 10) ^ rotr64(x3, 17);
        o[4] = x4 ^ rotr64(x4, 7) ^ rotr64(x4, 41);
        return o;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(logic [CNT_W-1:0] n);
        logic [WORD_W-1:0] m;
        unique case (n)
            4'd0:    m = 64'h0000000000000000;
            4'd1:    m = 64'hff00000000000000;
            4'd2:    m = 64'hffff000000000000;
            4'd3:    m = 64'hffffff0000000000;
            4'd4:    m = 64'hffffffff00000000;
            4'd5:    m = 64'hffffffffff000000;
            4'd6:    m = 64'hffffffffffff0000;
            4'd7:    m = 64'hffffffffffffff00;
            default: m = 64'hffffffffffffffff;
        endcase
        return m;
    endfunction

    // A full block takes its padding byte in the next, empty block.
    function automatic logic [WORD_W-1:0] pad_word(logic [CNT_W-1:0] n);
        logic [WORD_W-1:0] p;
        unique case (n)
            4'd1:    p = 64'h0080000000000000;
            4'd2:    p = 64'h0000800000000000;
            4'd3:    p = 64'h0000008000000000;
            4'd4:    p = 64'h0000000080000000;
            4'd5:    p = 64'h0000000000800000;
            4'd6:    p = 64'h0000000000008000;
            4'd7:    p = 64'h0000000000000080;
            default: p = 64'h8000000000000000;
        endcase
        return p;
    endfunction

endpackage

[sv/ascon_aead_stream_unit.sv]
// Ascon-128 authenticated cipher without associated data, one 64-bit block per beat.
// The user must write key and nonce through the configuration port only while the unit is idle; not enforced.
// The input channel takes a block with its mode, byte count and first/last marks.
// A first block, or any block when no message is open, loads key, nonce and IV
// and runs twelve initialization rounds before the block is absorbed.
// Each block produces exactly one output beat carrying ciphertext or plaintext.
// A last block also carries the tag and, on decrypt, the tag compare result.
// One permutation round runs per cycle in a single shared round unit, so an
// ordinary block keeps the input stalled after acceptance through absorb, six
// rounds and result, and is accepted again once the unit is back in idle.
// A first block adds 12 initialization rounds; a last block adds 6 rounds, or 12 when full.
// The result lands in an output register once the work ends and the register is free.
// While the receiver stalls, that register holds its beat; the next block can
// still be accepted and processed, and waits for the register before finishing.
// Reset clears the key, nonce, sponge state and the open-message flag.
module ascon_aead_stream_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ascon_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ascon_pkg::t_in_beat               i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ascon_pkg::t_out_beat              o_out_beat
);
    import ascon_pkg::*;

    t_state             r_state, n_state;
    t_sponge            r_sponge, n_sponge;
    logic [RND_W-1:0]   r_rnd, n_rnd;
    logic               r_open, n_open;
    logic [63:0]        r_key_high, r_key_low, r_nonce_high, r_nonce_low;
    logic               r_kind;
    logic [63:0]        r_data;
    logic [CNT_W-1:0]   r_n;
    logic               r_last;
    logic               r_start;
    logic [127:0]       r_exp_tag;
    logic [63:0]        r_res, n_res;
    t_out_beat          r_out;
    logic               r_out_valid, n_out_valid;

    logic               in_accept;
    logic               out_load;
    logic               round_end;
    t_sponge            round_out;
    logic [63:0]        mask, plain, result;
    logic [CNT_W-1:0]   in_n;
    logic [127:0]       tag;
    t_out_beat          out_next;

    assign in_accept = i_in_valid && !o_in_stall;
    assign round_end = (r_rnd == ROUND_LAST);
    assign round_out = ascon_round(r_sponge, r_rnd);
    assign in_n      = (i_in_beat.byte_count > FULL_BYTES || !i_in_beat.last_block)
                       ? FULL_BYTES : i_in_beat.byte_count;

    assign mask   = byte_mask(r_n);
    assign plain  = r_kind ? ((r_sponge[0] ^ r_data) & mask) : (r_data & mask);
    assign result = r_kind ? plain : ((r_sponge[0] ^ plain) & mask);
    assign tag    = {r_sponge[3] ^ r_key_high, r_sponge[4] ^ r_key_low};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_beat.first_block || !r_open) begin
                        n_state = ST_INIT;
                    end else begin
                        n_state = ST_ABSORB;
                    end
                end
            end
            ST_INIT: begin
                if (round_end) begin
                    n_state = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                if (r_last && r_n != FULL_BYTES) begin
                    n_state = ST_FINAL;
                end else begin
                    n_state = ST_BLOCK;
                end
            end
            ST_BLOCK: begin
                if (round_end) begin
                    n_state = r_last ? ST_FINAL : ST_DONE;
                end
            end
            ST_FINAL: begin
                if (round_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_sponge    = r_sponge;
        n_rnd       = r_rnd;
        n_open      = r_open;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_open = !i_in_beat.last_block;
                    if (i_in_beat.first_block || !r_open) begin
                        n_sponge = {r_nonce_low, r_nonce_high, r_key_low, r_key_high,
                                    ASCON128_IV};
                        n_rnd    = INIT_START;
                    end
                end
            end
            ST_INIT: begin
                n_sponge = round_out;
                n_rnd    = r_rnd + 1'b1;
                if (round_end) begin
                    n_sponge[3] = round_out[3] ^ r_key_high;
                    n_sponge[4] = round_out[4] ^ r_key_low ^ DOMAIN_SEP;
                end
            end
            ST_ABSORB: begin
                n_res       = result;
                n_sponge[0] = r_sponge[0] ^ plain;
                if (r_last && r_n != FULL_BYTES) begin
                    n_sponge[0] = r_sponge[0] ^ plain ^ pad_word(r_n);
                    n_sponge[1] = r_sponge[1] ^ r_key_high;
                    n_sponge[2] = r_sponge[2] ^ r_key_low;
                    n_rnd       = INIT_START;
                end else begin
                    n_rnd = BLOCK_START;
                end
            end
            ST_BLOCK: begin
                n_sponge = round_out;
                n_rnd    = r_rnd + 1'b1;
                if (round_end && r_last) begin
                    n_sponge[0] = round_out[0] ^ pad_word(FULL_BYTES);
                    n_sponge[1] = round_out[1] ^ r_key_high;
                    n_sponge[2] = round_out[2] ^ r_key_low;
                    n_rnd       = INIT_START;
                end
            end
            ST_FINAL: begin
                n_sponge = round_out;
                n_rnd    = r_rnd + 1'b1;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_rnd = INIT_START;
            end
        endcase
    end

    always_comb begin
        out_next.out_data       = r_res;
        out_next.out_byte_count = r_n;
        out_next.tag_high       = r_last ? tag[127:64] : 64'd0;
        out_next.tag_low        = r_last ? tag[63:0] : 64'd0;
        out_next.tag_valid      = r_last;
        out_next.auth_ok        = r_last && r_kind && (tag == r_exp_tag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sponge     <= '0;
            r_rnd        <= INIT_START;
            r_open       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_nonce_high <= '0;
            r_nonce_low  <= '0;
        end else begin
            r_state     <= n_state;
            r_sponge    <= n_sponge;
            r_rnd       <= n_rnd;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                    CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                    CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                    CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                    default:        r_key_high   <= r_key_high;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= i_in_beat.kind;
            r_data    <= i_in_beat.block_data;
            r_n       <= in_n;
            r_last    <= i_in_beat.last_block;
            r_start   <= i_in_beat.first_block || !r_open;
            r_exp_tag <= {i_in_beat.expected_tag_high, i_in_beat.expected_tag_low};
        end
        r_res <= n_res;
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_start_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_state == ST_INIT) == r_start))
        else $error("Block start did not match the initialization decision.");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !out_load) |=> (r_state == ST_DONE))
        else $error("Finished block left before its result was stored.");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |-> r_last)
        else $error("Finalization entered for a block that is not last.");

    a_block_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLOCK) |-> (r_rnd >= BLOCK_START))
        else $error("Block permutation ran with an initialization round index.");

    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (!r_open && o_out_valid && o_out_beat.tag_valid))
        else $error("Last block did not close the message with a tag.");

endmodule
